### sv/srtf_pkg.sv
package srtf_pkg;

  // Job store depth and derived widths.
  localparam int MaxJobs = 16;
  localparam int IdxW    = $clog2(MaxJobs);
  localparam int CntW    = $clog2(MaxJobs + 1);

  // Field widths fixed by the interface.
  localparam int ValW  = 16;
  localparam int RemW  = 17;
  localparam int TimeW = 22;
  localparam int JobW  = 6;
  localparam int InDataW  = 32;
  localparam int OutDataW = 56;

  localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};
  localparam logic [RemW-1:0]  NoJobRem = {RemW{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_APPLY,
    ST_EMIT_RD,
    ST_EMIT_CALC,
    ST_EMIT_OUT
  } srtf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the job on the input
    logic scan_start;  // clear scan accumulators and the index
    logic scan_run;    // step the scan over the job store
    logic decide;      // pick the running job and the time step
    logic apply;       // retire the time step
    logic emit_start;  // clear the index for the result pass
    logic emit_calc;   // compute the waiting time of the current job
    logic emit_out;    // load the output register
    logic run_clear;   // clear the set after its last result
  } srtf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic pending;
    logic go_apply;
    logic out_free;
    logic emit_last;
  } srtf_stat_t;

endpackage

### sv/srtf_schedule_waiting_times.sv
// Preemptive shortest-remaining-time-first scheduler. Jobs arrive on the slave
// stream, one transfer per cycle, each carrying its arrival tick and burst
// length; the transfer with tlast set is the final job of the set and starts the
// run. Up to 16 jobs are held; further jobs of the same set are dropped. The run
// scans the job store once per scheduling event (an arrival or a completion):
// each scan steps through the jobs on the single store read port, followed by
// a decision state and, whenever a job holds the processor, an update state; a
// stretch with no job arrived yet is skipped in the decision state alone. The
// input is not ready during the run. Afterwards one result per job is sent on
// the master stream, in load order, one at a time through a read, a calculation
// and an output state, which waits while a pending result is not yet taken;
// tlast marks the last result, and the block is then ready for the next set. A
// result held in the output register does not block loading of the next set.
module srtf_schedule_waiting_times (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] arrival tick, [31:16] burst length
  input  logic        s_axis_tlast_i,   // last_job
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [5:0] job_number, [27:6] waiting_time,
                                        // [49:28] turnaround, [55:50] zero
  output logic        m_axis_tlast_o    // last_result
);

  srtf_pkg::srtf_cmd_t  cmd;
  srtf_pkg::srtf_stat_t stat;

  // The controller sequences loading, the event scans and the result pass.
  srtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the job stores, the scheduler state and the result register.
  srtf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .arrival_i   (s_axis_tdata_i[15:0]),
    .burst_i     (s_axis_tdata_i[31:16]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

### sv/srtf_ctrl.sv
module srtf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  srtf_pkg::srtf_stat_t stat_i,
  output srtf_pkg::srtf_cmd_t  cmd_o
);

  srtf_pkg::srtf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtf_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      srtf_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_start = 1'b1;
            state_d          = srtf_pkg::ST_SCAN;
          end
        end
      end
      srtf_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_d = srtf_pkg::ST_DECIDE;
        end
      end
      srtf_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (!stat_i.pending) begin
          cmd_o.emit_start = 1'b1;
          state_d          = srtf_pkg::ST_EMIT_RD;
        end else if (stat_i.go_apply) begin
          state_d = srtf_pkg::ST_APPLY;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = srtf_pkg::ST_SCAN;
        end
      end
      srtf_pkg::ST_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = srtf_pkg::ST_SCAN;
      end
      srtf_pkg::ST_EMIT_RD: begin
        state_d = srtf_pkg::ST_EMIT_CALC;
      end
      srtf_pkg::ST_EMIT_CALC: begin
        cmd_o.emit_calc = 1'b1;
        state_d         = srtf_pkg::ST_EMIT_OUT;
      end
      srtf_pkg::ST_EMIT_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.run_clear = 1'b1;
            state_d         = srtf_pkg::ST_LOAD;
          end else begin
            state_d = srtf_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = srtf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

### sv/srtf_dp.sv
module srtf_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srtf_pkg::srtf_cmd_t             cmd_i,
  output srtf_pkg::srtf_stat_t            stat_o,
  input  logic [srtf_pkg::ValW-1:0]       arrival_i,
  input  logic [srtf_pkg::ValW-1:0]       burst_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [srtf_pkg::OutDataW-1:0]   out_data_o,
  output logic                            out_last_o
);

  // Job stores, one read address per cycle with registered read data.
  logic [srtf_pkg::ValW-1:0]  arr_mem [srtf_pkg::MaxJobs];
  logic [srtf_pkg::ValW-1:0]  bur_mem [srtf_pkg::MaxJobs];
  logic [srtf_pkg::ValW-1:0]  rem_mem [srtf_pkg::MaxJobs];
  logic [srtf_pkg::TimeW-1:0] fin_mem [srtf_pkg::MaxJobs];

  logic [srtf_pkg::ValW-1:0]  arr_rd_q, bur_rd_q, rem_rd_q;
  logic [srtf_pkg::TimeW-1:0] fin_rd_q;
  logic [srtf_pkg::IdxW-1:0]  rd_addr;

  logic [srtf_pkg::CntW-1:0]  job_count_q;
  logic [srtf_pkg::CntW-1:0]  idx_q;
  logic                       pipe_vld_q;
  logic [srtf_pkg::IdxW-1:0]  pipe_idx_q;
  logic [srtf_pkg::TimeW-1:0] tick_q;
  logic                       rv_q;
  logic [srtf_pkg::IdxW-1:0]  rj_q;
  logic [srtf_pkg::RemW-1:0]  rrem_q;
  logic [srtf_pkg::ValW-1:0]  d_q;

  // Scan accumulators.
  logic                       found_q, pend_q, later_q;
  logic [srtf_pkg::IdxW-1:0]  cj_q;
  logic [srtf_pkg::ValW-1:0]  crem_q, carr_q, narr_q;

  logic [srtf_pkg::TimeW-1:0] wt_q;
  logic [srtf_pkg::ValW-1:0]  bq_q;
  logic                       out_vld_q;
  logic [srtf_pkg::OutDataW-1:0] out_data_q;
  logic                       out_last_q;

  logic                       issue;
  logic                       a_later, is_running, better;
  logic                       sw, rv_eff;
  logic [srtf_pkg::IdxW-1:0]  new_rj;
  logic [srtf_pkg::ValW-1:0]  new_rem, d_next, rem_after;
  logic [srtf_pkg::TimeW-1:0] gap, tick_after;
  logic                       load_wr;
  logic [srtf_pkg::IdxW-1:0]  load_addr;
  logic [srtf_pkg::ValW:0]    used;
  logic [srtf_pkg::TimeW-1:0] wt_next;
  logic [srtf_pkg::TimeW:0]   tat_full;
  logic [srtf_pkg::TimeW-1:0] tat_sat;
  logic                       emit_last;

  assign rd_addr   = idx_q[srtf_pkg::IdxW-1:0];
  assign issue     = cmd_i.scan_run && (idx_q < job_count_q);
  assign load_wr   = cmd_i.load && (job_count_q < srtf_pkg::CntW'(srtf_pkg::MaxJobs));
  assign load_addr = job_count_q[srtf_pkg::IdxW-1:0];

  // Scan step on the job whose data was read in the previous cycle.
  assign a_later    = {{(srtf_pkg::TimeW-srtf_pkg::ValW){1'b0}}, arr_rd_q} > tick_q;
  assign is_running = rv_q && (pipe_idx_q == rj_q);
  assign better     = !found_q || (rem_rd_q < crem_q) ||
                      ((rem_rd_q == crem_q) && (arr_rd_q < carr_q));

  // Decision after a scan.
  assign sw      = found_q && (!rv_q || ({1'b0, crem_q} < rrem_q));
  assign rv_eff  = rv_q || sw;
  assign new_rj  = sw ? cj_q : rj_q;
  assign new_rem = sw ? crem_q : rrem_q[srtf_pkg::ValW-1:0];
  assign gap     = {{(srtf_pkg::TimeW-srtf_pkg::ValW){1'b0}}, narr_q} - tick_q;
  assign d_next  = (later_q && (gap < {{(srtf_pkg::TimeW-srtf_pkg::ValW){1'b0}}, new_rem}))
                   ? gap[srtf_pkg::ValW-1:0] : new_rem;

  assign rem_after  = rrem_q[srtf_pkg::ValW-1:0] - d_q;
  assign tick_after = tick_q + {{(srtf_pkg::TimeW-srtf_pkg::ValW){1'b0}}, d_q};

  // Result arithmetic.
  assign used     = {1'b0, bur_rd_q} + {1'b0, arr_rd_q};
  assign wt_next  = ((bur_rd_q != '0) &&
                     (fin_rd_q > {{(srtf_pkg::TimeW-srtf_pkg::ValW-1){1'b0}}, used}))
                    ? fin_rd_q - {{(srtf_pkg::TimeW-srtf_pkg::ValW-1){1'b0}}, used} : '0;
  assign tat_full = {{(srtf_pkg::TimeW-srtf_pkg::ValW+1){1'b0}}, bq_q} + {1'b0, wt_q};
  assign tat_sat  = tat_full[srtf_pkg::TimeW] ? srtf_pkg::TimeMax
                                              : tat_full[srtf_pkg::TimeW-1:0];
  assign emit_last = (idx_q == job_count_q - srtf_pkg::CntW'(1));

  assign stat_o.scan_done = (idx_q >= job_count_q) && !pipe_vld_q;
  assign stat_o.pending   = pend_q;
  assign stat_o.go_apply  = rv_eff;
  assign stat_o.out_free  = !out_vld_q || out_ready_i;
  assign stat_o.emit_last = emit_last;

  always_ff @(posedge clk_i) begin
    arr_rd_q <= arr_mem[rd_addr];
    bur_rd_q <= bur_mem[rd_addr];
    rem_rd_q <= rem_mem[rd_addr];
    fin_rd_q <= fin_mem[rd_addr];
    if (load_wr) begin
      arr_mem[load_addr] <= arrival_i;
      bur_mem[load_addr] <= burst_i;
      rem_mem[load_addr] <= burst_i;
    end else if (cmd_i.apply) begin
      rem_mem[rj_q] <= rem_after;
    end
    if (cmd_i.apply && (rem_after == '0)) begin
      fin_mem[rj_q] <= tick_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q <= '0;
      idx_q       <= '0;
      pipe_vld_q  <= 1'b0;
      tick_q      <= '0;
      rv_q        <= 1'b0;
      rrem_q      <= srtf_pkg::NoJobRem;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      later_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (load_wr) begin
        job_count_q <= job_count_q + srtf_pkg::CntW'(1);
      end
      pipe_vld_q <= issue;
      if (cmd_i.scan_start || cmd_i.emit_start) begin
        idx_q <= '0;
      end else if (issue || cmd_i.emit_out) begin
        idx_q <= idx_q + srtf_pkg::CntW'(1);
      end
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
        pend_q  <= 1'b0;
        later_q <= 1'b0;
      end else if (pipe_vld_q && (rem_rd_q != '0)) begin
        pend_q <= 1'b1;
        if (a_later) begin
          later_q <= 1'b1;
        end else if (!is_running && better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.decide) begin
        rv_q <= rv_eff;
        if (sw) begin
          rrem_q <= {1'b0, crem_q};
        end
        if (!rv_eff) begin
          tick_q <= {{(srtf_pkg::TimeW-srtf_pkg::ValW){1'b0}}, narr_q};
        end
      end
      if (cmd_i.apply) begin
        tick_q <= tick_after;
        if (rem_after == '0) begin
          rv_q   <= 1'b0;
          rrem_q <= srtf_pkg::NoJobRem;
        end else begin
          rrem_q <= {1'b0, rem_after};
        end
      end
      if (cmd_i.run_clear) begin
        job_count_q <= '0;
        tick_q      <= '0;
        rv_q        <= 1'b0;
        rrem_q      <= srtf_pkg::NoJobRem;
      end
      if (cmd_i.emit_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= rd_addr;
    if (pipe_vld_q && (rem_rd_q != '0)) begin
      if (a_later) begin
        if (!later_q || (arr_rd_q < narr_q)) begin
          narr_q <= arr_rd_q;
        end
      end else if (!is_running && better) begin
        cj_q   <= pipe_idx_q;
        crem_q <= rem_rd_q;
        carr_q <= arr_rd_q;
      end
    end
    if (cmd_i.decide) begin
      rj_q <= new_rj;
      d_q  <= d_next;
    end
    if (cmd_i.emit_calc) begin
      wt_q <= wt_next;
      bq_q <= bur_rd_q;
    end
    if (cmd_i.emit_out) begin
      out_data_q <= {{(srtf_pkg::OutDataW-srtf_pkg::JobW-2*srtf_pkg::TimeW){1'b0}},
                     tat_sat, wt_q, srtf_pkg::JobW'(idx_q[srtf_pkg::IdxW-1:0])};
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_count_q <= srtf_pkg::CntW'(srtf_pkg::MaxJobs))
    else $error("job count exceeds the store depth");

  a_running_rem_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (rrem_q[srtf_pkg::RemW-1] == 1'b0) && (rrem_q != '0))
    else $error("running job has no valid remaining time");

  a_idle_rem_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rv_q |-> (rrem_q == srtf_pkg::NoJobRem))
    else $error("remaining time set with no running job");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_out |-> (!out_vld_q || out_ready_i))
    else $error("result register loaded while a result is pending");

endmodule
